// ===== hdl/phg_pkg.sv =====
// ----------------------------------------------------------------------------
// phg_pkg
// Shared widths, constants and codes of the coverage pheromone grid.
// ----------------------------------------------------------------------------
package phg_pkg;

  // field widths
  localparam int unsigned PosW    = 16;
  localparam int unsigned LevelW  = 9;
  localparam int unsigned CellW   = 16;
  localparam int unsigned RangeW  = 16;
  localparam int unsigned CountW  = 7;
  localparam int unsigned FracW   = 9;

  // stream and configuration port widths
  localparam int unsigned InDataW  = 48;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // shared multiplier: a 24 bit operand times a 12 bit half
  localparam int unsigned MulAW = 24;
  localparam int unsigned MulBW = 12;
  localparam int unsigned MulPW = MulAW + MulBW;
  localparam int unsigned AccW  = 2 * MulAW + 1;

  // quotient bits of the coverage fraction
  localparam int unsigned DivSteps = 9;

  localparam logic [LevelW-1:0] LevelOne = 9'd256;
  localparam logic [CountW-1:0] CountMax = 7'd127;

  localparam logic [CellW-1:0]  CellSizeRst  = 16'd160;
  localparam logic [RangeW-1:0] RangeRst     = 16'd160;
  localparam logic [LevelW-1:0] ThresholdRst = 9'd64;
  localparam logic [LevelW-1:0] DecayRst     = 9'd205;

  typedef enum logic [1:0] {
    OP_MARK  = 2'd0,
    OP_QUERY = 2'd1,
    OP_DECAY = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CELL_SIZE       = 2'd0,
    CFG_SENSING_RANGE   = 2'd1,
    CFG_SENSE_THRESHOLD = 2'd2,
    CFG_DECAY_FACTOR    = 2'd3
  } cfg_reg_e;

endpackage

// ===== hdl/phg_mul.sv =====
// ----------------------------------------------------------------------------
// phg_mul
// Shared registered multiplier used for squares, the range square and decay.
// ----------------------------------------------------------------------------
module phg_mul import phg_pkg::*; (
  input  logic             clk_i,
  input  logic [MulAW-1:0] a_i,
  input  logic [MulBW-1:0] b_i,
  output logic [MulPW-1:0] p_o
);

  logic [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== hdl/phg_div.sv =====
// ----------------------------------------------------------------------------
// phg_div
// Restoring divider giving floor(num*256/den) one quotient bit per cycle,
// for num not above den.
// ----------------------------------------------------------------------------
module phg_div import phg_pkg::*; #(
  parameter int unsigned CntW = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CntW-1:0]  num_i,
  input  logic [CntW-1:0]  den_i,
  output logic             done_o,
  output logic [FracW-1:0] quot_o
);

  localparam int unsigned StepW = $clog2(DivSteps);
  localparam logic [StepW-1:0] LastStep = StepW'(DivSteps - 1);

  logic             busy_q, done_q, first_q;
  logic [StepW-1:0] step_q;
  logic [CntW:0]    rem_q;
  logic [CntW-1:0]  den_q;
  logic [FracW-1:0] quot_q;
  logic [CntW:0]    trial;
  logic             ge;

  // remainder stays below den, so the shift loses nothing
  assign trial = first_q ? rem_q : {rem_q[CntW-1:0], 1'b0};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      first_q <= 1'b0;
      step_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        first_q <= 1'b1;
        step_q  <= '0;
      end else if (busy_q) begin
        first_q <= 1'b0;
        step_q  <= step_q + 1'b1;
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q  <= ge ? (trial - {1'b0, den_q}) : trial;
      quot_q <= {quot_q[FracW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hdl/coverage_pheromone_grid.sv =====
// ----------------------------------------------------------------------------
// coverage_pheromone_grid
// Square grid of Q1.8 pheromone levels with mark, coverage query and decay.
// ----------------------------------------------------------------------------
// After reset the block sweeps the grid memory to zero, one cell a cycle, and
// takes no word meanwhile. Each word is then worked through cell by cell by
// one sequencer around a single registered 24x12 multiplier and one grid
// memory port. A mark or query first squares the range in low half, high half
// and final sum, then for each cell squares both axis distances in two halves
// each and makes the range compare; a query then adds an end step and, when
// any cell is in range, the nine-step divider that gives the fraction. A decay
// reads, multiplies and writes back each cell in turn. The done step holds
// while an earlier result word waits on the output. Exactly one result word
// is returned per input word; the block is ready only between words.
// ----------------------------------------------------------------------------
module coverage_pheromone_grid import phg_pkg::*; #(
  parameter int unsigned GRID_CELLS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // pos_x, pos_y, deposit, zero pad
  input  logic [InUserW-1:0]  s_axis_tuser,  // operation
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // cells_in_range, marked_cells,
                                             // coverage_fraction, zero pad
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned Cells   = GRID_CELLS * GRID_CELLS;
  localparam int unsigned AddrW   = $clog2(Cells);
  localparam int unsigned GIdxW   = $clog2(GRID_CELLS);
  localparam int unsigned CntW    = $clog2(Cells + 1);
  localparam int unsigned CentreW = CellW + $clog2(2 * GRID_CELLS);
  localparam int unsigned SatW    = (CntW > CountW) ? CntW : CountW;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Cells - 1);
  localparam logic [GIdxW-1:0] LastG    = GIdxW'(GRID_CELLS - 1);

  typedef enum logic [16:0] {
    S_CLEAR = 17'h00001,
    S_IDLE  = 17'h00002,
    S_RL    = 17'h00004,
    S_RH    = 17'h00008,
    S_RFIN  = 17'h00010,
    S_PREP  = 17'h00020,
    S_DXL   = 17'h00040,
    S_DXH   = 17'h00080,
    S_DYL   = 17'h00100,
    S_DYH   = 17'h00200,
    S_CMP   = 17'h00400,
    S_QEND  = 17'h00800,
    S_DIV   = 17'h01000,
    S_DRD   = 17'h02000,
    S_DMUL  = 17'h04000,
    S_DWR   = 17'h08000,
    S_DONE  = 17'h10000
  } state_e;

  state_e state_q, state_d;

  logic [CellW-1:0]  cell_size_q;
  logic [RangeW-1:0] range_q;
  logic [LevelW-1:0] thr_q, decay_q;

  op_e               op_q;
  logic [PosW-1:0]   px_q, py_q;
  logic [LevelW-1:0] dep_q;

  logic [AddrW-1:0]   addr_q;
  logic [GIdxW-1:0]   gy_q;
  logic [CentreW-1:0] cx_q, cy_q, adx_q, ady_q;
  logic [AccW-1:0]    acc_q, rsq_q;
  logic [CntW-1:0]    total_q, marked_q;

  logic [LevelW-1:0] mem_q [Cells];
  logic [LevelW-1:0] rd_q;
  logic              mem_we;
  logic [LevelW-1:0] mem_wd;

  logic              out_valid_q;
  logic [CountW-1:0] out_total_q, out_marked_q;
  logic [FracW-1:0]  out_frac_q;

  logic               in_accept, out_load, step_cell, in_range, div_start, div_done;
  logic [FracW-1:0]   div_quot;
  logic [MulAW-1:0]   mul_a, r2_ext, adx_ext, ady_ext;
  logic [MulBW-1:0]   mul_b;
  logic [MulPW-1:0]   mul_p;
  logic [AccW-1:0]    sq_sum;
  logic [CentreW-1:0] px2, py2, twice_cs, adx_c, ady_c;
  logic [LevelW:0]    mark_sum;
  logic [LevelW-1:0]  mark_val, dec_raw, dec_val;
  logic [SatW-1:0]    total_ext, marked_ext;
  logic [CountW-1:0]  total_sat, marked_sat;

  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign step_cell     = (state_q == S_CMP) || (state_q == S_DWR);
  assign div_start     = (state_q == S_QEND) && (total_q != '0);
  assign cfg_ready_o   = 1'b1;

  // ---------------------------------------------------------------- geometry
  assign px2      = CentreW'({px_q, 1'b0});
  assign py2      = CentreW'({py_q, 1'b0});
  assign twice_cs = CentreW'({cell_size_q, 1'b0});
  assign adx_c    = (cx_q >= px2) ? (cx_q - px2) : (px2 - cx_q);
  assign ady_c    = (cy_q >= py2) ? (cy_q - py2) : (py2 - cy_q);

  assign r2_ext  = MulAW'({range_q, 1'b0});
  assign adx_ext = MulAW'(adx_q);
  assign ady_ext = MulAW'(ady_q);

  // squares are built from low and high halves of the operand
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_RL: begin
        mul_a = r2_ext;
        mul_b = r2_ext[MulBW-1:0];
      end
      S_RH: begin
        mul_a = r2_ext;
        mul_b = r2_ext[MulAW-1:MulBW];
      end
      S_DXL: begin
        mul_a = adx_ext;
        mul_b = adx_ext[MulBW-1:0];
      end
      S_DXH: begin
        mul_a = adx_ext;
        mul_b = adx_ext[MulAW-1:MulBW];
      end
      S_DYL: begin
        mul_a = ady_ext;
        mul_b = ady_ext[MulBW-1:0];
      end
      S_DYH: begin
        mul_a = ady_ext;
        mul_b = ady_ext[MulAW-1:MulBW];
      end
      S_DMUL: begin
        mul_a = MulAW'(rd_q);
        mul_b = MulBW'(decay_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  phg_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign sq_sum   = acc_q + AccW'({mul_p, {MulBW{1'b0}}});
  assign in_range = (sq_sum <= rsq_q);

  // ------------------------------------------------------------ cell update
  assign mark_sum = {1'b0, rd_q} + {1'b0, dep_q};
  assign mark_val = (mark_sum > {1'b0, LevelOne}) ? LevelOne : mark_sum[LevelW-1:0];
  assign dec_raw  = mul_p[LevelW+7:8];
  assign dec_val  = (dec_raw > LevelOne) ? LevelOne : dec_raw;

  always_comb begin
    mem_we = 1'b0;
    mem_wd = '0;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = '0;
      end
      S_CMP: begin
        mem_we = (op_q == OP_MARK) && in_range;
        mem_wd = mark_val;
      end
      S_DWR: begin
        mem_we = 1'b1;
        mem_wd = dec_val;
      end
      default: begin
        mem_we = 1'b0;
        mem_wd = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= mem_wd;
    end
    rd_q <= mem_q[addr_q];
  end

  // ---------------------------------------------------------------- divider
  phg_div #(
    .CntW (CntW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (marked_q),
    .den_i   (total_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // -------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (addr_q == LastAddr) state_d = S_IDLE;
      S_IDLE: begin
        if (in_accept) begin
          case (op_e'(s_axis_tuser))
            OP_MARK, OP_QUERY: state_d = S_RL;
            OP_DECAY:          state_d = S_DRD;
            default:           state_d = S_DONE;
          endcase
        end
      end
      S_RL:   state_d = S_RH;
      S_RH:   state_d = S_RFIN;
      S_RFIN: state_d = S_PREP;
      S_PREP: state_d = S_DXL;
      S_DXL:  state_d = S_DXH;
      S_DXH:  state_d = S_DYL;
      S_DYL:  state_d = S_DYH;
      S_DYH:  state_d = S_CMP;
      S_CMP: begin
        if (addr_q != LastAddr) begin
          state_d = S_PREP;
        end else if (op_q == OP_QUERY) begin
          state_d = S_QEND;
        end else begin
          state_d = S_DONE;
        end
      end
      S_QEND: state_d = (total_q != '0) ? S_DIV : S_DONE;
      S_DIV:  if (div_done) state_d = S_DONE;
      S_DRD:  state_d = S_DMUL;
      S_DMUL: state_d = S_DWR;
      S_DWR:  state_d = (addr_q == LastAddr) ? S_DONE : S_DRD;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      addr_q      <= '0;
      gy_q        <= '0;
      total_q     <= '0;
      marked_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (in_accept) begin
        addr_q   <= '0;
        gy_q     <= '0;
        total_q  <= '0;
        marked_q <= '0;
      end else begin
        if (step_cell || (state_q == S_CLEAR)) begin
          addr_q <= addr_q + 1'b1;
        end
        if (step_cell) begin
          gy_q <= (gy_q == LastG) ? '0 : (gy_q + 1'b1);
        end
        if ((state_q == S_CMP) && (op_q == OP_QUERY) && in_range) begin
          total_q <= total_q + 1'b1;
          if (rd_q >= thr_q) begin
            marked_q <= marked_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= CellSizeRst;
      range_q     <= RangeRst;
      thr_q       <= ThresholdRst;
      decay_q     <= DecayRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_CELL_SIZE:       cell_size_q <= cfg_data_i[CellW-1:0];
        CFG_SENSING_RANGE:   range_q     <= cfg_data_i[RangeW-1:0];
        CFG_SENSE_THRESHOLD: thr_q       <= cfg_data_i[LevelW-1:0];
        CFG_DECAY_FACTOR:    decay_q     <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= op_e'(s_axis_tuser);
      px_q  <= s_axis_tdata[15:0];
      py_q  <= s_axis_tdata[31:16];
      dep_q <= s_axis_tdata[40:32];
      cx_q  <= CentreW'(cell_size_q);
      cy_q  <= CentreW'(cell_size_q);
    end else if (step_cell) begin
      // centres move by one cell edge in doubled units
      if (gy_q == LastG) begin
        cx_q <= cx_q + twice_cs;
        cy_q <= CentreW'(cell_size_q);
      end else begin
        cy_q <= cy_q + twice_cs;
      end
    end
    if (state_q == S_PREP) begin
      adx_q <= adx_c;
      ady_q <= ady_c;
    end
    case (state_q)
      S_RH, S_DXH: acc_q <= AccW'(mul_p);
      S_DYL:       acc_q <= sq_sum;
      S_DYH:       acc_q <= acc_q + AccW'(mul_p);
      default: ;
    endcase
    if (state_q == S_RFIN) begin
      rsq_q <= sq_sum;
    end
    if (out_load) begin
      if (op_q == OP_QUERY) begin
        out_total_q  <= total_sat;
        out_marked_q <= marked_sat;
        out_frac_q   <= (total_q == '0) ? '0 : div_quot;
      end else begin
        out_total_q  <= '0;
        out_marked_q <= '0;
        out_frac_q   <= '0;
      end
    end
  end

  assign total_ext  = SatW'(total_q);
  assign marked_ext = SatW'(marked_q);
  assign total_sat  = (total_ext > SatW'(CountMax)) ? CountMax : total_ext[CountW-1:0];
  assign marked_sat = (marked_ext > SatW'(CountMax)) ? CountMax : marked_ext[CountW-1:0];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'({out_frac_q, out_marked_q, out_total_q});

  // -------------------------------------------------------------- assertions
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
    else $error("result word raised outside the done step");

  a_addr_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_DONE && state_q != S_QEND && state_q != S_DIV)
      |-> (addr_q <= LastAddr))
    else $error("cell address beyond the grid");

  a_marked_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    marked_q <= total_q)
    else $error("marked count above in-range count");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide step");

  a_query_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP && op_q == OP_QUERY) |-> !mem_we)
    else $error("grid written during a query");

endmodule

// ===== tb/tb_coverage_pheromone_grid.sv =====
// ----------------------------------------------------------------------------
// tb_coverage_pheromone_grid
// Self-checking bench for the coverage pheromone grid.
// ----------------------------------------------------------------------------
// Drives mark, coverage query, decay and unused-operation words into the
// stream input and keeps its own copy of the 10x10 level grid and registers.
// Each accepted word yields one predicted result, which the checker compares
// field by field with the returned word. A directed part covers register
// extremes, saturation and empty coverage; random phases follow, each with
// fresh register settings and random gaps on both streams, and a quiet tail.
// ----------------------------------------------------------------------------
module tb_coverage_pheromone_grid import phg_pkg::*; ();

  localparam int unsigned GridN      = 10;
  localparam int          CycleLimit = 2_000_000;
  localparam logic [1:0]  OpUnused   = 2'd3;

  typedef struct packed {
    logic [CountW-1:0] cells;
    logic [CountW-1:0] marked;
    logic [FracW-1:0]  frac;
  } cover_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;  // pos_x, pos_y, deposit, zero pad
  logic [InUserW-1:0]  s_axis_tuser = '0;  // operation
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;       // cells_in_range, marked_cells,
                                           // coverage_fraction, zero pad
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_CELL_SIZE;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // shadow of the block state
  logic [LevelW-1:0]   level_grid [GridN*GridN];
  logic [CellW-1:0]    cell_len   = CellSizeRst;
  logic [RangeW-1:0]   sense_rad  = RangeRst;
  logic [LevelW-1:0]   mark_level = ThresholdRst;
  logic [LevelW-1:0]   decay_mult = DecayRst;

  cover_result_t       coverage_due [$];
  int                  mismatches = 0;
  int                  cycles = 0;
  int                  ready_hold = 0;
  bit                  gaps_on = 1'b1;

  coverage_pheromone_grid #(.GRID_CELLS(GridN)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, coverage_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // centre test in doubled units, exact
  function automatic bit cell_covered(int gx, int gy, logic [PosW-1:0] px,
                                      logic [PosW-1:0] py);
    longint dx, dy, r2;
    dx = longint'(2 * gx + 1) * longint'(cell_len) - 2 * longint'(px);
    dy = longint'(2 * gy + 1) * longint'(cell_len) - 2 * longint'(py);
    r2 = 2 * longint'(sense_rad);
    return (dx * dx + dy * dy) <= r2 * r2;
  endfunction

  function automatic cover_result_t grid_step(logic [1:0] op, logic [PosW-1:0] px,
                                              logic [PosW-1:0] py,
                                              logic [LevelW-1:0] dep);
    cover_result_t r;
    int unsigned   total, marked, sum, idx;
    total = 0;
    marked = 0;
    for (int gx = 0; gx < GridN; gx++) begin
      for (int gy = 0; gy < GridN; gy++) begin
        idx = gx * GridN + gy;
        case (op)
          OP_MARK: begin
            if (cell_covered(gx, gy, px, py)) begin
              sum = level_grid[idx] + dep;
              level_grid[idx] = (sum > LevelOne) ? LevelOne : LevelW'(sum);
            end
          end
          OP_QUERY: begin
            if (cell_covered(gx, gy, px, py)) begin
              total++;
              if (level_grid[idx] >= mark_level) marked++;
            end
          end
          OP_DECAY: begin
            sum = (level_grid[idx] * decay_mult) >> 8;
            level_grid[idx] = (sum > LevelOne) ? LevelOne : LevelW'(sum);
          end
          default: ;
        endcase
      end
    end
    r.cells  = (total > CountMax) ? CountMax : CountW'(total);
    r.marked = (marked > CountMax) ? CountMax : CountW'(marked);
    r.frac   = (op == OP_QUERY && total > 0) ? FracW'((marked * 256) / total) : '0;
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin : check_word
      cover_result_t want, got;
      got.cells  = m_axis_tdata[6:0];
      got.marked = m_axis_tdata[13:7];
      got.frac   = m_axis_tdata[22:14];
      if (coverage_due.size() == 0) begin
        $display("%0t unexpected result word %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = coverage_due.pop_front();
        if (got.cells !== want.cells) begin
          $display("%0t cells_in_range expected %0d actual %0d", $time, want.cells,
                   got.cells);
          mismatches++;
        end
        if (got.marked !== want.marked) begin
          $display("%0t marked_cells expected %0d actual %0d", $time, want.marked,
                   got.marked);
          mismatches++;
        end
        if (got.frac !== want.frac) begin
          $display("%0t coverage_fraction expected %0d actual %0d", $time, want.frac,
                   got.frac);
          mismatches++;
        end
      end
    end
  end

  // result side back-pressure in short bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      m_axis_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      ready_hold = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // leaves tvalid high so the next word can follow without a gap
  task automatic send_item(logic [1:0] op, logic [PosW-1:0] px, logic [PosW-1:0] py,
                           logic [LevelW-1:0] dep);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      // sometimes hold back until the block is ready, so the gap lands there
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk_i); while (!s_axis_tready);
      end
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, dep, py, px};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    coverage_due = {coverage_due, grid_step(op, px, py, dep)};
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (coverage_due.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CELL_SIZE:       cell_len   = val;
      CFG_SENSING_RANGE:   sense_rad  = val;
      CFG_SENSE_THRESHOLD: mark_level = val[LevelW-1:0];
      CFG_DECAY_FACTOR:    decay_mult = val[LevelW-1:0];
      default: ;
    endcase
  endtask

  // called only with no result outstanding
  task automatic set_registers(logic [CellW-1:0] cs, logic [RangeW-1:0] rng,
                               logic [LevelW-1:0] thr, logic [LevelW-1:0] dec);
    logic [6:0] junk_t, junk_d;
    // bits above the nine-bit registers are ignored
    junk_t = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'd0;
    junk_d = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'd0;
    write_reg(CFG_CELL_SIZE, cs);
    write_reg(CFG_SENSING_RANGE, rng);
    write_reg(CFG_SENSE_THRESHOLD, {junk_t, thr});
    write_reg(CFG_DECAY_FACTOR, {junk_d, dec});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_item();
    int               pick, span;
    logic [1:0]       op;
    logic [PosW-1:0]  px, py;
    logic [LevelW-1:0] dep;
    span = 11 * int'(cell_len);
    if (span > 65535) span = 65535;
    pick = $urandom_range(0, 99);
    if (pick < 40)      op = OP_MARK;
    else if (pick < 75) op = OP_QUERY;
    else if (pick < 87) op = OP_DECAY;
    else if (pick < 92) op = OpUnused;
    else                op = 2'($urandom);
    if ($urandom_range(0, 99) < 85) begin
      px = PosW'($urandom_range(0, span));
      py = PosW'($urandom_range(0, span));
    end else begin
      px = PosW'($urandom);
      py = PosW'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 70)      dep = LevelW'($urandom_range(0, 128));
    else if (pick < 85) dep = LevelOne;
    else                dep = LevelW'($urandom);
    send_item(op, px, py, dep);
  endtask

  task automatic test_basic_ops();
    send_item(OP_QUERY, 16'd800, 16'd800, 9'd0);
    send_item(OP_MARK, 16'd800, 16'd800, LevelOne);
    send_item(OP_QUERY, 16'd800, 16'd800, 9'd0);
    // deposit above one still saturates
    send_item(OP_MARK, 16'd0, 16'd0, 9'h1FF);
    send_item(OP_MARK, 16'hFFFF, 16'hFFFF, 9'd0);
    send_item(OP_QUERY, 16'd0, 16'd0, 9'd0);
    send_item(OP_DECAY, 16'd0, 16'd0, 9'd0);
    send_item(OP_QUERY, 16'd800, 16'd800, 9'd0);
    send_item(OpUnused, 16'hA5A5, 16'h5A5A, 9'h155);
    send_item(OP_QUERY, 16'hFFFF, 16'hFFFF, 9'd0);
    drain_results();
  endtask

  task automatic test_register_extremes();
    // whole grid in range, everything marked, decay factor above one
    set_registers(16'd160, 16'hFFFF, 9'd0, 9'h1FF);
    send_item(OP_QUERY, 16'd800, 16'd800, 9'd0);
    send_item(OP_DECAY, 16'd0, 16'd0, 9'd0);
    send_item(OP_QUERY, 16'd800, 16'd800, 9'd0);
    drain_results();
    // threshold above one marks nothing, zero decay clears
    set_registers(16'd160, 16'hFFFF, 9'h1FF, 9'd0);
    send_item(OP_QUERY, 16'd800, 16'd800, 9'd0);
    send_item(OP_DECAY, 16'd0, 16'd0, 9'd0);
    send_item(OP_QUERY, 16'd100, 16'd900, 9'd0);
    drain_results();
    // zero cell size puts every centre at the origin
    set_registers(16'd0, 16'd0, LevelOne, LevelOne);
    send_item(OP_MARK, 16'd0, 16'd0, LevelOne);
    send_item(OP_QUERY, 16'd0, 16'd0, 9'd0);
    send_item(OP_DECAY, 16'd0, 16'd0, 9'd0);
    send_item(OP_QUERY, 16'd1, 16'd0, 9'd0);
    drain_results();
    set_registers(16'hFFFF, 16'hFFFF, 9'd1, DecayRst);
    send_item(OP_QUERY, 16'hFFFF, 16'hFFFF, 9'd0);
    send_item(OP_MARK, 16'd32767, 16'd32767, 9'h1FF);
    send_item(OP_QUERY, 16'd0, 16'hFFFF, 9'd0);
    drain_results();
    set_registers(CellSizeRst, RangeRst, ThresholdRst, DecayRst);
  endtask

  task automatic test_random_phases();
    int               pick;
    logic [CellW-1:0]  cs;
    logic [RangeW-1:0] rng;
    logic [LevelW-1:0] thr, dec;
    for (int ph = 0; ph < 7; ph++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)       cs = CellW'($urandom_range(20, 400));
      else if (pick == 7) cs = 16'd1;
      else if (pick == 8) cs = CellW'($urandom);
      else                cs = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'd0;
      pick = $urandom_range(0, 9);
      if (pick < 7)       rng = RangeW'($urandom_range(0, (3 * int'(cs) > 65535) ?
                                                             65535 : 3 * int'(cs)));
      else if (pick == 7) rng = 16'd0;
      else if (pick == 8) rng = 16'hFFFF;
      else                rng = RangeW'($urandom);
      pick = $urandom_range(0, 19);
      if (pick < 14)      thr = LevelW'($urandom_range(1, 256));
      else if (pick < 17) thr = ($urandom_range(0, 1) == 1) ? LevelOne : 9'd0;
      else                thr = LevelW'($urandom_range(257, 511));
      pick = $urandom_range(0, 9);
      if (pick < 6)       dec = LevelW'($urandom_range(128, 256));
      else if (pick < 8)  dec = LevelW'($urandom);
      else                dec = (pick == 8) ? 9'd0 : 9'h1FF;
      set_registers(cs, rng, thr, dec);
      for (int n = 0; n < 80; n++) begin
        // sender holds off once until the block has answered everything
        if (ph == 3 && n == 40) drain_results();
        send_random_item();
      end
      drain_results();
    end
  endtask

  task automatic test_quiet_tail();
    gaps_on = 1'b0;
    set_registers(16'd120, 16'd260, 9'd96, 9'd230);
    for (int n = 0; n < 90; n++) send_random_item();
    drain_results();
  endtask

  initial begin
    for (int i = 0; i < GridN * GridN; i++) level_grid[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basic_ops();
    test_register_extremes();
    test_random_phases();
    test_quiet_tail();
    repeat (650) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/phg_pkg.sv
hdl/phg_mul.sv
hdl/phg_div.sv
hdl/coverage_pheromone_grid.sv
tb/tb_coverage_pheromone_grid.sv
